@@ src/acs_pkg.sv @@
// Shared types, constants and arithmetic helpers for the ADC capture statistics block.
`default_nettype none

package acs_pkg;

	// Field and state widths
	localparam int CODE_W      = 12;
	localparam int BAND_W      = 11;
	localparam int SUM_W       = 27;
	localparam int COUNT_W     = 16;
	localparam int EDGE_W      = 15;
	localparam int EDGE_SUM_W  = EDGE_W + 1;
	localparam int MV_W        = 12;
	localparam int PROD_W      = 24;
	localparam int THR_W       = 25;
	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W  = 12;

	// Scale and limits
	localparam int FULL_SCALE_MV = 3300;
	localparam int CODE_MAX      = 4095;
	localparam int EDGE_LIMIT    = 32767;
	localparam int MAX_SAMPLES   = 32768;

	// Register reset values and the band edges they give
	localparam int CENTRE_RST = 1623;
	localparam int BAND_RST   = 50;
	localparam logic [THR_W-1:0] LOWER_THR_RST =
		THR_W'((CENTRE_RST - BAND_RST) * CODE_MAX);
	localparam logic [THR_W-1:0] UPPER_THR_RST =
		THR_W'((CENTRE_RST + BAND_RST) * CODE_MAX);
	localparam logic [MV_W-1:0] LOW_MV_RST = MV_W'(FULL_SCALE_MV);

	// Classifier thresholds
	localparam int GROUP_EDGES = 7;
	localparam int BUSY_EDGES  = 44;
	localparam int PP_BUSY_HI  = 2900;
	localparam int PP_MID_HI   = 2050;
	localparam int PP_QUIET_LO = 1000;
	localparam int PP_QUIET_HI = 2100;
	localparam int MAX_MV_HI   = 1800;

	// Register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_CENTRE_MV = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_BAND_MV   = CFG_INDEX_W'(1);

	// Decision classes CON1..CON4
	typedef enum logic [1:0] {
		CLS_CON1 = 2'd0,
		CLS_CON2 = 2'd1,
		CLS_CON3 = 2'd2,
		CLS_CON4 = 2'd3
	} class_t;

	// Band edges scaled to code*3300 units
	typedef struct packed {
		logic [THR_W-1:0] lower;
		logic [THR_W-1:0] upper;
	} thr_t;

	// Sample word after the scaling stage
	typedef struct packed {
		logic [CODE_W-1:0] sample;
		logic [MV_W-1:0]   mv;
		logic [PROD_W-1:0] scaled;
		logic              above;
		logic              below;
		logic              last;
	} scaled_t;

	// floor(scaled / 4095): split at 4096, then one correction step
	function automatic logic [MV_W-1:0] scaled_to_mv(input logic [PROD_W-1:0] scaled);
		logic [MV_W-1:0]   q0;
		logic [MV_W:0]     r;
		q0 = scaled[PROD_W-1:CODE_W];
		r  = {1'b0, scaled[CODE_W-1:0]} + {1'b0, q0};
		return (r >= (MV_W+1)'(CODE_MAX)) ? q0 + MV_W'(1) : q0;
	endfunction

	// Two-level class decision
	function automatic class_t classify(
		input logic [EDGE_SUM_W-1:0] edges,
		input logic [MV_W-1:0]       pp,
		input logic [MV_W-1:0]       max_mv
	);
		class_t c;
		priority if (edges >= EDGE_SUM_W'(GROUP_EDGES)) begin
			if (edges > EDGE_SUM_W'(BUSY_EDGES)) begin
				c = (pp > MV_W'(PP_BUSY_HI)) ? CLS_CON2 : CLS_CON1;
			end else begin
				c = (pp > MV_W'(PP_MID_HI)) ? CLS_CON4 : CLS_CON3;
			end
		end else if (pp < MV_W'(PP_QUIET_LO)) begin
			c = CLS_CON3;
		end else if (pp < MV_W'(PP_QUIET_HI)) begin
			c = (max_mv > MV_W'(MAX_MV_HI)) ? CLS_CON1 : CLS_CON4;
		end else begin
			c = CLS_CON2;
		end
		return c;
	endfunction

endpackage

`default_nettype wire

@@ src/adc_capture_stats_classifier.sv @@
// Top level of the ADC capture statistics and classifier block.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+--------------------------------------------
//   input    | in_valid / in_ready   | sample, last
//   result   | out_valid / out_ready | sample_sum .. class_code, one per capture
//   config   | cfg_we                | cfg_index, cfg_data (0 centre_mv, 1 band_mv)
//
// One word per cycle while in_ready is high; after its final word is accepted, a result is valid
// once that word has passed the scaling register, then the stats and result register.
// The scaled band edges follow a register write through the band register, then the edge register.
// Reset restores the band registers and clears the capture state.
// A word that ends a capture (last set, or the sample limit reached) waits in the scaling stage only
// while an earlier result is not taken; other words keep flowing into the capture.
`default_nettype none

module adc_capture_stats_classifier (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [acs_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [acs_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [acs_pkg::CODE_W-1:0]       sample,
	input  wire logic                             last,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [acs_pkg::SUM_W-1:0]             sample_sum,
	output logic [acs_pkg::COUNT_W-1:0]           sample_count,
	output logic [acs_pkg::CODE_W-1:0]            max_code,
	output logic [acs_pkg::CODE_W-1:0]            min_code,
	output logic [acs_pkg::EDGE_W-1:0]            rise_count,
	output logic [acs_pkg::EDGE_W-1:0]            fall_count,
	output logic [acs_pkg::MV_W-1:0]              peak_mv,
	output logic                                  group,
	output logic [1:0]                            class_code
);
	import acs_pkg::*;

	thr_t    thr;
	logic    s2_valid;
	logic    s2_ready;
	scaled_t s2_word;

	// Band registers
	acs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.thr       (thr)
	);

	// Input and scaling stages
	acs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sample   (sample),
		.last     (last),
		.thr      (thr),
		.s2_valid (s2_valid),
		.s2_ready (s2_ready),
		.s2_word  (s2_word)
	);

	// Statistics and result register
	acs_stats u_stats (
		.clk          (clk),
		.arst_n       (arst_n),
		.thr          (thr),
		.s2_valid     (s2_valid),
		.s2_ready     (s2_ready),
		.s2_word      (s2_word),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.sample_sum   (sample_sum),
		.sample_count (sample_count),
		.max_code     (max_code),
		.min_code     (min_code),
		.rise_count   (rise_count),
		.fall_count   (fall_count),
		.peak_mv      (peak_mv),
		.group        (group),
		.class_code   (class_code)
	);

endmodule

`default_nettype wire

@@ src/acs_cfg.sv @@
// Band registers and the scaled band edges derived from them.
`default_nettype none

module acs_cfg (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [acs_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [acs_pkg::CFG_DATA_W-1:0]   cfg_data,
	output acs_pkg::thr_t                         thr
);
	import acs_pkg::*;

	logic [CODE_W-1:0] centre_q;
	logic [BAND_W-1:0] band_q;
	thr_t              thr_q;
	logic [CODE_W-1:0] lower_mv;
	logic [CODE_W:0]   upper_mv;

	// Write the band registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			centre_q <= CODE_W'(CENTRE_RST);
			band_q   <= BAND_W'(BAND_RST);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CENTRE_MV: centre_q <= cfg_data[CODE_W-1:0];
				REG_BAND_MV:   band_q   <= cfg_data[BAND_W-1:0];
				default: ;
			endcase
		end
	end

	// Band edges in mV, lower edge clamped at zero
	always_comb begin
		lower_mv = (centre_q > CODE_W'(band_q)) ? centre_q - CODE_W'(band_q) : '0;
		upper_mv = {1'b0, centre_q} + (CODE_W+1)'(band_q);
	end

	// Hold the edges scaled by 4095 so that the sample path only compares
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q.lower <= LOWER_THR_RST;
			thr_q.upper <= UPPER_THR_RST;
		end else begin
			thr_q.lower <= THR_W'(lower_mv) * THR_W'(CODE_MAX);
			thr_q.upper <= THR_W'(upper_mv) * THR_W'(CODE_MAX);
		end
	end

	assign thr = thr_q;

endmodule

`default_nettype wire

@@ src/acs_front.sv @@
// Input register and scaling stage: mV conversion and band edge compares.
`default_nettype none

module acs_front (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [acs_pkg::CODE_W-1:0]  sample,
	input  wire logic                        last,
	input  wire acs_pkg::thr_t               thr,
	output logic                             s2_valid,
	input  wire logic                        s2_ready,
	output acs_pkg::scaled_t                 s2_word
);
	import acs_pkg::*;

	logic              valid_s1;
	logic [CODE_W-1:0] sample_s1;
	logic              last_s1;
	logic              valid_s2;
	scaled_t           word_s2;
	logic              s2_free;
	logic [PROD_W-1:0] scaled;
	scaled_t           word_next;

	assign s2_free  = !valid_s2 || s2_ready;
	assign in_ready = !valid_s1 || s2_free;

	// Scale the held sample and compare against the band edges
	always_comb begin
		scaled           = PROD_W'(sample_s1) * PROD_W'(FULL_SCALE_MV);
		word_next.sample = sample_s1;
		word_next.mv     = scaled_to_mv(scaled);
		word_next.scaled = scaled;
		word_next.above  = {1'b0, scaled} > thr.upper;
		word_next.below  = {1'b0, scaled} < thr.lower;
		word_next.last   = last_s1;
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sample_s1 <= sample;
			last_s1   <= last;
		end
	end

	// Scaled word register; advance when the stats stage takes the word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && valid_s1) begin
			word_s2 <= word_next;
		end
	end

	assign s2_valid = valid_s2;
	assign s2_word  = word_s2;

endmodule

`default_nettype wire

@@ src/acs_stats.sv @@
// Capture statistics, crossing counters, classifier and result register.
`default_nettype none

module acs_stats (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire acs_pkg::thr_t               thr,
	input  wire logic                        s2_valid,
	output logic                             s2_ready,
	input  wire acs_pkg::scaled_t            s2_word,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [acs_pkg::SUM_W-1:0]        sample_sum,
	output logic [acs_pkg::COUNT_W-1:0]      sample_count,
	output logic [acs_pkg::CODE_W-1:0]       max_code,
	output logic [acs_pkg::CODE_W-1:0]       min_code,
	output logic [acs_pkg::EDGE_W-1:0]       rise_count,
	output logic [acs_pkg::EDGE_W-1:0]       fall_count,
	output logic [acs_pkg::MV_W-1:0]         peak_mv,
	output logic                             group,
	output logic [1:0]                       class_code
);
	import acs_pkg::*;

	// Running capture state
	logic [SUM_W-1:0]   sum_q;
	logic [COUNT_W-1:0] count_q;
	logic [CODE_W-1:0]  high_q;
	logic [CODE_W-1:0]  low_q;
	logic [MV_W-1:0]    high_mv_q;
	logic [MV_W-1:0]    low_mv_q;
	logic [EDGE_W-1:0]  rises_q;
	logic [EDGE_W-1:0]  falls_q;
	logic [PROD_W-1:0]  prev_scaled_q;

	// Result register
	logic               res_valid_q;
	logic [SUM_W-1:0]   res_sum_q;
	logic [COUNT_W-1:0] res_count_q;
	logic [CODE_W-1:0]  res_max_q;
	logic [CODE_W-1:0]  res_min_q;
	logic [EDGE_W-1:0]  res_rise_q;
	logic [EDGE_W-1:0]  res_fall_q;
	logic [MV_W-1:0]    res_pp_q;
	logic               res_group_q;
	class_t             res_class_q;

	// Next state
	logic [SUM_W-1:0]      sum_n;
	logic [COUNT_W-1:0]    count_n;
	logic [CODE_W-1:0]     high_n;
	logic [CODE_W-1:0]     low_n;
	logic [MV_W-1:0]       high_mv_n;
	logic [MV_W-1:0]       low_mv_n;
	logic [EDGE_W-1:0]     rises_n;
	logic [EDGE_W-1:0]     falls_n;
	logic                  prev_below;
	logic                  prev_above;
	logic [EDGE_SUM_W-1:0] edges;
	logic [MV_W-1:0]       pp;
	logic                  emit;
	logic                  go;

	// Fold the current word into the capture
	always_comb begin
		prev_below = {1'b0, prev_scaled_q} < thr.lower;
		prev_above = {1'b0, prev_scaled_q} > thr.upper;
		sum_n      = sum_q + SUM_W'(s2_word.sample);
		count_n    = count_q + COUNT_W'(1);
		if (s2_word.sample > high_q) begin
			high_n    = s2_word.sample;
			high_mv_n = s2_word.mv;
		end else begin
			high_n    = high_q;
			high_mv_n = high_mv_q;
		end
		if (s2_word.sample < low_q) begin
			low_n    = s2_word.sample;
			low_mv_n = s2_word.mv;
		end else begin
			low_n    = low_q;
			low_mv_n = low_mv_q;
		end
		rises_n = rises_q;
		if (prev_below && s2_word.above && rises_q != EDGE_W'(EDGE_LIMIT)) begin
			rises_n = rises_q + EDGE_W'(1);
		end
		falls_n = falls_q;
		if (s2_word.below && prev_above && falls_q != EDGE_W'(EDGE_LIMIT)) begin
			falls_n = falls_q + EDGE_W'(1);
		end
		edges = EDGE_SUM_W'(rises_n) + EDGE_SUM_W'(falls_n);
		pp    = (high_mv_n >= low_mv_n) ? high_mv_n - low_mv_n : '0;
		emit  = s2_word.last || (count_n == COUNT_W'(MAX_SAMPLES));
	end

	// Stall only a word that ends a capture while the result still waits
	assign s2_ready = !emit || !res_valid_q || out_ready;
	assign go       = s2_valid && s2_ready;

	// Update the capture state, clear it after the final word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q         <= '0;
			count_q       <= '0;
			high_q        <= '0;
			low_q         <= CODE_W'(CODE_MAX);
			high_mv_q     <= '0;
			low_mv_q      <= LOW_MV_RST;
			rises_q       <= '0;
			falls_q       <= '0;
			prev_scaled_q <= '0;
		end else if (go) begin
			if (emit) begin
				sum_q         <= '0;
				count_q       <= '0;
				high_q        <= '0;
				low_q         <= CODE_W'(CODE_MAX);
				high_mv_q     <= '0;
				low_mv_q      <= LOW_MV_RST;
				rises_q       <= '0;
				falls_q       <= '0;
				prev_scaled_q <= '0;
			end else begin
				sum_q         <= sum_n;
				count_q       <= count_n;
				high_q        <= high_n;
				low_q         <= low_n;
				high_mv_q     <= high_mv_n;
				low_mv_q      <= low_mv_n;
				rises_q       <= rises_n;
				falls_q       <= falls_n;
				prev_scaled_q <= s2_word.scaled;
			end
		end
	end

	// Result valid: set on a finished capture, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (go && emit) begin
			res_valid_q <= 1'b1;
		end else if (out_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && emit) begin
			res_sum_q   <= sum_n;
			res_count_q <= count_n;
			res_max_q   <= high_n;
			res_min_q   <= low_n;
			res_rise_q  <= rises_n;
			res_fall_q  <= falls_n;
			res_pp_q    <= pp;
			res_group_q <= (edges < EDGE_SUM_W'(GROUP_EDGES));
			res_class_q <= classify(edges, pp, high_mv_n);
		end
	end

	assign out_valid    = res_valid_q;
	assign sample_sum   = res_sum_q;
	assign sample_count = res_count_q;
	assign max_code     = res_max_q;
	assign min_code     = res_min_q;
	assign rise_count   = res_rise_q;
	assign fall_count   = res_fall_q;
	assign peak_mv      = res_pp_q;
	assign group        = res_group_q;
	assign class_code   = res_class_q;

endmodule

`default_nettype wire

@@ src/acs_checker.sv @@
// Port-level checks on the result channel, bound to the top level.
`default_nettype none

module acs_checker (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             out_valid,
	input  wire logic                             out_ready,
	input  wire logic [acs_pkg::SUM_W-1:0]        sample_sum,
	input  wire logic [acs_pkg::COUNT_W-1:0]      sample_count,
	input  wire logic [acs_pkg::CODE_W-1:0]       max_code,
	input  wire logic [acs_pkg::CODE_W-1:0]       min_code,
	input  wire logic [acs_pkg::EDGE_W-1:0]       rise_count,
	input  wire logic [acs_pkg::EDGE_W-1:0]       fall_count,
	input  wire logic [acs_pkg::MV_W-1:0]         peak_mv,
	input  wire logic                             group,
	input  wire logic [1:0]                       class_code
);
	import acs_pkg::*;

	// A waiting result holds its word
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sample_sum)
			&& $stable(sample_count) && $stable(peak_mv) && $stable(class_code))
		else $error("result word changed while stalled");

	// A capture holds at least one word and no more than the limit
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> sample_count != '0
			&& COUNT_W'(sample_count - COUNT_W'(1)) < COUNT_W'(MAX_SAMPLES))
		else $error("sample count out of range");

	// Extremes are ordered and the peak fits full scale
	a_extremes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> max_code >= min_code && peak_mv <= MV_W'(FULL_SCALE_MV))
		else $error("min/max or peak out of order");

	// Group follows the total edge count
	a_group: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> group ==
			((EDGE_SUM_W'(rise_count) + EDGE_SUM_W'(fall_count)) < EDGE_SUM_W'(GROUP_EDGES)))
		else $error("group disagrees with edge count");

	// Sum of a capture lies between count*min and count*max
	a_sum_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (SUM_W+CODE_W)'(sample_sum)
			<= (SUM_W+CODE_W)'(sample_count) * (SUM_W+CODE_W)'(max_code)
			&& (SUM_W+CODE_W)'(sample_sum)
			>= (SUM_W+CODE_W)'(sample_count) * (SUM_W+CODE_W)'(min_code))
		else $error("sum outside count times extremes");

endmodule

bind adc_capture_stats_classifier acs_checker u_acs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.sample_sum   (sample_sum),
	.sample_count (sample_count),
	.max_code     (max_code),
	.min_code     (min_code),
	.rise_count   (rise_count),
	.fall_count   (fall_count),
	.peak_mv      (peak_mv),
	.group        (group),
	.class_code   (class_code)
);

`default_nettype wire

@@ tb/adc_capture_stats_classifier_tb.sv @@
// Self-checking testbench for the ADC capture statistics and classifier block.
`timescale 1ns / 100ps

// Statistics that one finished capture reports
typedef struct packed {
	logic [acs_pkg::SUM_W-1:0]   sum;
	logic [acs_pkg::COUNT_W-1:0] count;
	logic [acs_pkg::CODE_W-1:0]  hi_code;
	logic [acs_pkg::CODE_W-1:0]  lo_code;
	logic [acs_pkg::EDGE_W-1:0]  rises;
	logic [acs_pkg::EDGE_W-1:0]  falls;
	logic [acs_pkg::MV_W-1:0]    peak;
	logic                        grp;
	acs_pkg::class_t             cls;
} capture_stats_t;

// Capture statistics predictor and queue of reports still due
class capture_scoreboard;
	logic [acs_pkg::CODE_W-1:0]  centre_mv;
	logic [acs_pkg::BAND_W-1:0]  band_mv;
	logic [acs_pkg::SUM_W:0]     acc_sum;
	logic [acs_pkg::COUNT_W-1:0] acc_count;
	logic [acs_pkg::CODE_W-1:0]  hi_code;
	logic [acs_pkg::CODE_W-1:0]  lo_code;
	logic [acs_pkg::CODE_W-1:0]  prev_code;
	logic [acs_pkg::EDGE_W-1:0]  rises;
	logic [acs_pkg::EDGE_W-1:0]  falls;
	capture_stats_t              stats_due[$];
	int                          errors;
	int                          results_seen;

	function new();
		centre_mv    = acs_pkg::CODE_W'(acs_pkg::CENTRE_RST);
		band_mv      = acs_pkg::BAND_W'(acs_pkg::BAND_RST);
		errors       = 0;
		results_seen = 0;
		clear_capture();
	endfunction

	function void clear_capture();
		acc_sum   = '0;
		acc_count = '0;
		hi_code   = '0;
		lo_code   = acs_pkg::CODE_W'(acs_pkg::CODE_MAX);
		prev_code = '0;
		rises     = '0;
		falls     = '0;
	endfunction

	// Unknown indexes fall through untouched
	function void write_reg(logic [acs_pkg::CFG_INDEX_W-1:0] idx,
			logic [acs_pkg::CFG_DATA_W-1:0] data);
		if (idx == acs_pkg::REG_CENTRE_MV) begin
			centre_mv = data;
		end else if (idx == acs_pkg::REG_BAND_MV) begin
			band_mv = data[acs_pkg::BAND_W-1:0];
		end
	endfunction

	function int pending();
		return stats_due.size();
	endfunction

	function acs_pkg::class_t pick_class(int unsigned edges, int unsigned pp,
			int unsigned max_mv);
		if (edges >= acs_pkg::GROUP_EDGES) begin
			if (edges > acs_pkg::BUSY_EDGES)
				return (pp > acs_pkg::PP_BUSY_HI) ? acs_pkg::CLS_CON2 : acs_pkg::CLS_CON1;
			return (pp > acs_pkg::PP_MID_HI) ? acs_pkg::CLS_CON4 : acs_pkg::CLS_CON3;
		end
		if (pp < acs_pkg::PP_QUIET_LO)
			return acs_pkg::CLS_CON3;
		if (pp < acs_pkg::PP_QUIET_HI)
			return (max_mv > acs_pkg::MAX_MV_HI) ? acs_pkg::CLS_CON1 : acs_pkg::CLS_CON4;
		return acs_pkg::CLS_CON2;
	endfunction

	// Accumulate one accepted word; queue a report when the capture closes
	function void note_word(logic [acs_pkg::CODE_W-1:0] code, logic fin);
		int unsigned    lower, upper, lo_thr, hi_thr, prev_s, cur_s;
		int unsigned    max_mv, min_mv, pp, edges;
		capture_stats_t st;
		lower  = (centre_mv > band_mv) ? centre_mv - band_mv : 0;
		upper  = centre_mv + band_mv;
		lo_thr = lower * acs_pkg::CODE_MAX;
		hi_thr = upper * acs_pkg::CODE_MAX;
		prev_s = prev_code * acs_pkg::FULL_SCALE_MV;
		cur_s  = code * acs_pkg::FULL_SCALE_MV;
		acc_sum   = acc_sum + code;
		acc_count = acc_count + 1'b1;
		if (code > hi_code)
			hi_code = code;
		if (code < lo_code)
			lo_code = code;
		// Crossings must jump the whole band; counters saturate
		if (prev_s < lo_thr && cur_s > hi_thr && rises < acs_pkg::EDGE_LIMIT)
			rises = rises + 1'b1;
		if (cur_s < lo_thr && prev_s > hi_thr && falls < acs_pkg::EDGE_LIMIT)
			falls = falls + 1'b1;
		prev_code = code;
		if (!fin && acc_count < acs_pkg::MAX_SAMPLES)
			return;
		max_mv = (hi_code * acs_pkg::FULL_SCALE_MV) / acs_pkg::CODE_MAX;
		min_mv = (lo_code * acs_pkg::FULL_SCALE_MV) / acs_pkg::CODE_MAX;
		pp     = (max_mv >= min_mv) ? max_mv - min_mv : 0;
		edges  = rises + falls;
		st.sum     = acc_sum[acs_pkg::SUM_W-1:0];
		st.count   = acc_count;
		st.hi_code = hi_code;
		st.lo_code = lo_code;
		st.rises   = rises;
		st.falls   = falls;
		st.peak    = pp[acs_pkg::MV_W-1:0];
		st.grp     = (edges >= acs_pkg::GROUP_EDGES) ? 1'b0 : 1'b1;
		st.cls     = pick_class(edges, pp, max_mv);
		stats_due.push_back(st);
		clear_capture();
	endfunction

	task report(string msg);
		errors++;
		if (errors <= 100)
			$display("mismatch at %0t: %s", $time, msg);
	endtask

	task compare_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report($sformatf("report %0d: %s is %0d, expected %0d",
				results_seen, name, got, want));
	endtask

	// Compare an accepted report with the oldest one due
	task check_result(capture_stats_t got);
		capture_stats_t want;
		if (stats_due.size() == 0) begin
			report($sformatf("unexpected report, sum %0d count %0d", got.sum, got.count));
			return;
		end
		want = stats_due.pop_front();
		results_seen++;
		compare_field("sample_sum", got.sum, want.sum);
		compare_field("sample_count", got.count, want.count);
		compare_field("max_code", got.hi_code, want.hi_code);
		compare_field("min_code", got.lo_code, want.lo_code);
		compare_field("rise_count", got.rises, want.rises);
		compare_field("fall_count", got.falls, want.falls);
		compare_field("peak_mv", got.peak, want.peak);
		compare_field("group", got.grp, want.grp);
		compare_field("class_code", got.cls, want.cls);
	endtask
endclass

module adc_capture_stats_classifier_tb;
	import acs_pkg::*;

	localparam int STALL_LIMIT  = 400;
	localparam int PHASE_WORDS  = 140;
	localparam int PHASES       = 8;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   cfg_we    = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;
	logic                   in_valid  = 1'b0;
	logic                   in_ready;
	logic [CODE_W-1:0]      sample    = '0;
	logic                   last      = 1'b0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic [SUM_W-1:0]       sample_sum;
	logic [COUNT_W-1:0]     sample_count;
	logic [CODE_W-1:0]      max_code;
	logic [CODE_W-1:0]      min_code;
	logic [EDGE_W-1:0]      rise_count;
	logic [EDGE_W-1:0]      fall_count;
	logic [MV_W-1:0]        peak_mv;
	logic                   group;
	logic [1:0]             class_code;

	capture_scoreboard sb = new();
	bit                feed_gaps   = 1'b1;
	bit                drain_gaps  = 1'b1;
	int                words_sent  = 0;
	int                settings_done = 0;
	int                quiet_cycles = 0;

	adc_capture_stats_classifier i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.sample       (sample),
		.last         (last),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.sample_sum   (sample_sum),
		.sample_count (sample_count),
		.max_code     (max_code),
		.min_code     (min_code),
		.rise_count   (rise_count),
		.fall_count   (fall_count),
		.peak_mv      (peak_mv),
		.group        (group),
		.class_code   (class_code)
	);

	// Free-running 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hold reset for the first cycles only
	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Abort when neither channel moves a word for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("[adc_capture_stats_classifier] ERROR");
			$finish;
		end
	end

	// Accept reports with random stalls and check each one
	initial begin : result_sink
		int             stall;
		capture_stats_t got;
		while (!arst_n) @(posedge clk);
		forever begin
			stall = drain_gaps ? $urandom_range(0, 18) : 0;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			got.sum     = sample_sum;
			got.count   = sample_count;
			got.hi_code = max_code;
			got.lo_code = min_code;
			got.rises   = rise_count;
			got.falls   = fall_count;
			got.peak    = peak_mv;
			got.grp     = group;
			got.cls     = class_t'(class_code);
			sb.check_result(got);
		end
	end

	// Offer one sample word and hold it until accepted
	task automatic send_word(input logic [CODE_W-1:0] code, input logic fin);
		int gap;
		gap = feed_gaps ? $urandom_range(0, 18) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample   <= code;
		last     <= fin;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_word(code, fin);
		words_sent++;
	endtask

	// Drop valid and wait until every due report has been taken
	task automatic hold_until_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	// Write both band registers plus one write to an unused index
	task automatic configure(input logic [CFG_DATA_W-1:0] centre,
			input logic [CFG_DATA_W-1:0] band);
		hold_until_drained();
		repeat (6) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_CENTRE_MV;
		cfg_data  <= centre;
		@(posedge clk);
		sb.write_reg(REG_CENTRE_MV, centre);
		cfg_index <= REG_BAND_MV;
		cfg_data  <= band;
		@(posedge clk);
		sb.write_reg(REG_BAND_MV, band);
		cfg_index <= CFG_INDEX_W'($urandom_range(int'(REG_BAND_MV) + 1, 15));
		cfg_data  <= CFG_DATA_W'($urandom);
		@(posedge clk);
		sb.write_reg(cfg_index, cfg_data);
		cfg_we <= 1'b0;
		repeat (3) @(posedge clk);
		settings_done++;
	endtask

	// One capture: square wave between two levels, uniform noise, or noise of up to 2600 codes above a random floor
	task automatic send_capture(input int kind);
		int n, p, lo, hi, jit, v;
		n   = ($urandom_range(0, 9) < 6) ? $urandom_range(1, 20) : $urandom_range(21, 100);
		p   = $urandom_range(0, 1) ? 1 : $urandom_range(2, 5);
		jit = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 400) : 0;
		if (kind == 0 && $urandom_range(0, 3) == 0) begin
			lo = $urandom_range(0, 300);
			hi = $urandom_range(3795, 4095);
		end else if (kind == 2) begin
			lo = $urandom_range(0, 4095);
			hi = $urandom_range(0, 2600);
		end else begin
			lo = $urandom_range(0, 4095);
			hi = $urandom_range(0, 4095);
		end
		for (int i = 0; i < n; i++) begin
			case (kind)
			0: begin
				v = (((i / p) % 2) ? hi : lo) + int'($urandom_range(0, jit)) - jit / 2;
			end
			1: begin
				v = $urandom_range(0, 4095);
			end
			default: begin
				v = lo + int'($urandom_range(0, hi));
			end
			endcase
			if (v < 0)
				v = 0;
			if (v > CODE_MAX)
				v = CODE_MAX;
			send_word(CODE_W'(v), i == n - 1);
		end
	endtask

	initial begin : stimulus
		int                    goal, kind;
		logic [CFG_DATA_W-1:0] centre_set[PHASES];
		logic [CFG_DATA_W-1:0] band_set[PHASES];
		centre_set = '{12'd0, 12'd3300, 12'd4095, 12'd1623, 12'd0, 12'd3300, 12'd1000, 12'd0};
		band_set   = '{12'd0, 12'd1650, 12'hFFF, 12'd50, 12'd1650, 12'd0, 12'd2047, 12'd0};
		centre_set[7] = CFG_DATA_W'($urandom);
		band_set[7]   = CFG_DATA_W'($urandom);
		while (!arst_n) @(posedge clk);
		@(posedge clk);

		// Single-word captures: a first word above the band counts as a rise
		send_word(12'hFFF, 1'b1);
		send_word(12'h000, 1'b1);
		// Full-swing square wave: four rises and three falls
		for (int i = 0; i < 8; i++)
			send_word(i[0] ? 12'hFFF : 12'h000, i == 7);
		// Codes right at the reset band edges
		send_word(12'd1951, 1'b0);
		send_word(12'd2076, 1'b0);
		send_word(12'd1951, 1'b0);
		send_word(12'd2077, 1'b0);
		send_word(12'd1952, 1'b0);
		send_word(12'd2077, 1'b0);
		send_word(12'd1951, 1'b1);
		// Flat capture, zero peak-to-peak
		for (int i = 0; i < 3; i++)
			send_word(12'd2048, i == 2);

		// Random captures under each band setting
		for (int ph = 0; ph < PHASES; ph++) begin
			configure(centre_set[ph], band_set[ph]);
			goal = words_sent + PHASE_WORDS;
			while (words_sent < goal) begin
				feed_gaps  = $urandom_range(0, 3) != 0;
				drain_gaps = $urandom_range(0, 3) != 0;
				kind = $urandom_range(0, 9);
				send_capture((kind < 6) ? 0 : (kind < 8) ? 1 : 2);
				if ($urandom_range(0, 14) == 0)
					hold_until_drained();
			end
		end

		// Drain and let the pipeline settle
		hold_until_drained();
		repeat (8) @(posedge clk);
		if (sb.pending() != 0)
			sb.report($sformatf("%0d reports never arrived", sb.pending()));
		$display("covered %0d sample words in %0d captures over %0d band settings",
			words_sent, sb.results_seen, settings_done);
		$display("random stalls on both sides, %0d mismatches", sb.errors);
		if (sb.errors == 0)
			$display("[adc_capture_stats_classifier] OK");
		else
			$display("[adc_capture_stats_classifier] ERROR");
		$finish;
	end

endmodule
